### hdl/lidar_polar_to_cartesian_unit_assert.svh
// Assertion macros shared by the checker of the lidar polar to Cartesian unit.
`ifndef LIDAR_POLAR_TO_CARTESIAN_UNIT_ASSERT_SVH
`define LIDAR_POLAR_TO_CARTESIAN_UNIT_ASSERT_SVH

// Implication checked on every clock, muted while reset is held.
`define LPTC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked on every clock, reset included.
`define LPTC_ASSERT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hdl/lptc_pkg.sv
// Shared types, codes and tables of the lidar polar to Cartesian unit.
package lptc_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_START_ANGLE = 2'd0;
    localparam logic [1:0] REG_ANGLE_STEP  = 2'd1;

    // Quadrant codes from the two top angle bits
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // CORDIC datapath width and start vector (0.60725 in Q.30)
    localparam int CW = 34;
    localparam int TABLE_LEN = 24;
    typedef logic signed [CW-1:0] t_cw;
    localparam t_cw GAIN_START = 34'sd652032874;

    // Arctangent table, 2^-32 turn units
    localparam logic [31:0] ATAN_TURN [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    // Product and final sum widths
    localparam int MW = 57;
    localparam int SW = 34;
    typedef logic signed [MW-1:0] t_mul;
    typedef logic signed [SW-1:0] t_sum;
    localparam t_sum SAT_MAX = 34'sh0_7FFF_FFFF;
    localparam t_sum SAT_MIN = 34'sh3_8000_0000;
    localparam t_mul ROUND_HALF = 57'sd536870912;

    // Data carried alongside the angle through the pipeline
    typedef struct packed {
        logic [23:0]        range_value;
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic               scan_end;
        logic [1:0]         quad;
    } t_side;

endpackage

### hdl/lidar_polar_to_cartesian_unit.sv
// Top level of the lidar beam to world point converter.
// One beam request is taken in every clock cycle (busy stays low) and its
// world point comes out on o_valid after passing two angle stages, one
// CORDIC stage for each of the min(CORDIC_STAGES, 24) iterations, then
// quadrant fold, multiply, and round/offset/saturate stages.
// The result is shown for one cycle only; the receiver cannot stall it and
// must take it when o_valid is high. Write start_angle and angle_step only
// while no request is in flight.
module lidar_polar_to_cartesian_unit
    import lptc_pkg::*;
#(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16,
    parameter int INDEX_BITS    = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic [23:0]        i_range_value,
    input  logic [11:0]        i_beam_index,
    input  logic signed [31:0] i_pose_x,
    input  logic signed [31:0] i_pose_y,
    input  logic [15:0]        i_pose_heading,
    input  logic               i_scan_end,
    output logic               o_valid,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic               o_point_last,
    output logic               o_clipped
);

    localparam int NS = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    logic [15:0] r_start_angle, n_start_angle;
    logic [15:0] r_angle_step, n_angle_step;
    t_side       w_in_side;
    logic        w_v   [NS+1];
    t_cw         w_x   [NS+1];
    t_cw         w_y   [NS+1];
    t_cw         w_z   [NS+1];
    t_side       w_sd  [NS+1];

    // Pipeline never pushes back
    assign busy = 1'b0;

    // Configuration register writes
    always_comb begin
        n_start_angle = r_start_angle;
        n_angle_step  = r_angle_step;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_START_ANGLE: n_start_angle = i_cfg_data;
                REG_ANGLE_STEP:  n_angle_step  = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_angle <= '0;
            r_angle_step  <= '0;
        end else begin
            r_start_angle <= n_start_angle;
            r_angle_step  <= n_angle_step;
        end
    end

    // Request payload that rides along the angle pipeline
    always_comb begin
        w_in_side.range_value = i_range_value;
        w_in_side.pose_x      = i_pose_x;
        w_in_side.pose_y      = i_pose_y;
        w_in_side.scan_end    = i_scan_end;
        w_in_side.quad        = QUAD_0;
    end

    lptc_angle #(
        .ANGLE_BITS (ANGLE_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_angle (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (start & ~busy),
        .i_side         (w_in_side),
        .i_beam_index   (i_beam_index),
        .i_pose_heading (i_pose_heading),
        .i_start_angle  (r_start_angle),
        .i_angle_step   (r_angle_step),
        .o_valid        (w_v[0]),
        .o_z            (w_z[0]),
        .o_side         (w_sd[0])
    );

    assign w_x[0] = GAIN_START;
    assign w_y[0] = '0;

    // CORDIC chain, one registered iteration per stage
    for (genvar g = 0; g < NS; g++) begin : g_cordic
        lptc_cordic_stage #(
            .STAGE (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[g]),
            .i_x     (w_x[g]),
            .i_y     (w_y[g]),
            .i_z     (w_z[g]),
            .i_side  (w_sd[g]),
            .o_valid (w_v[g+1]),
            .o_x     (w_x[g+1]),
            .o_y     (w_y[g+1]),
            .o_z     (w_z[g+1]),
            .o_side  (w_sd[g+1])
        );
    end

    lptc_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_v[NS]),
        .i_x          (w_x[NS]),
        .i_y          (w_y[NS]),
        .i_side       (w_sd[NS]),
        .o_valid      (o_valid),
        .o_point_x    (o_point_x),
        .o_point_y    (o_point_y),
        .o_point_last (o_point_last),
        .o_clipped    (o_clipped)
    );

endmodule

### hdl/lptc_angle.sv
// Beam angle: heading + start + index * step, split into quadrant and residue.
module lptc_angle
    import lptc_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int INDEX_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_side       i_side,
    input  logic [11:0] i_beam_index,
    input  logic [15:0] i_pose_heading,
    input  logic [15:0] i_start_angle,
    input  logic [15:0] i_angle_step,
    output logic        o_valid,
    output t_cw         o_z,
    output t_side       o_side
);

    localparam int PW = INDEX_BITS + 16;

    logic                  r_valid_a, n_valid_a;
    logic [PW-1:0]         r_prod, n_prod;
    logic [ANGLE_BITS-1:0] r_base, n_base;
    t_side                 r_side_a;
    logic [ANGLE_BITS-1:0] w_ang;
    logic                  r_valid_b;
    t_cw                   r_z, n_z;
    t_side                 r_side_b, n_side_b;

    // Stage A: index product and the constant part of the angle
    always_comb begin
        n_valid_a = i_valid;
        n_prod    = PW'(INDEX_BITS'(i_beam_index)) * PW'(i_angle_step);
        n_base    = ANGLE_BITS'(i_pose_heading) + ANGLE_BITS'(i_start_angle);
    end

    // Stage B: wrap, quadrant, residue scaled to 2^-32 turn
    assign w_ang = r_base + ANGLE_BITS'(r_prod);

    always_comb begin
        n_z           = CW'({w_ang[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}});
        n_side_b      = r_side_a;
        n_side_b.quad = w_ang[ANGLE_BITS-1 -: 2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            r_valid_a <= n_valid_a;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod   <= n_prod;
        r_base   <= n_base;
        r_side_a <= i_side;
        r_z      <= n_z;
        r_side_b <= n_side_b;
    end

    assign o_valid = r_valid_b;
    assign o_z     = r_z;
    assign o_side  = r_side_b;

endmodule

### hdl/lptc_cordic_stage.sv
// One registered rotation-mode CORDIC iteration.
module lptc_cordic_stage
    import lptc_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_cw   i_x,
    input  t_cw   i_y,
    input  t_cw   i_z,
    input  t_side i_side,
    output logic  o_valid,
    output t_cw   o_x,
    output t_cw   o_y,
    output t_cw   o_z,
    output t_side o_side
);

    localparam t_cw ATAN = t_cw'(ATAN_TURN[STAGE]);

    logic  r_valid;
    t_cw   r_x, r_y, r_z;
    t_cw   n_x, n_y, n_z;
    t_cw   w_dx, w_dy;

    // Floor shifts, direction from the sign of the residual angle
    assign w_dx = i_y >>> STAGE;
    assign w_dy = i_x >>> STAGE;

    always_comb begin
        if (!i_z[CW-1]) begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        o_side <= i_side;
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

### hdl/lptc_scale.sv
// Quadrant fold, range scaling with rounding, pose offset and saturation.
module lptc_scale
    import lptc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_cw                i_x,
    input  t_cw                i_y,
    input  t_side              i_side,
    output logic               o_valid,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic               o_point_last,
    output logic               o_clipped
);

    logic               r_valid_f, r_valid_m, r_valid_o;
    logic signed [31:0] r_c, r_s, n_c, n_s;
    t_side              r_side_f, r_side_m;
    t_mul               r_mx, r_my, n_mx, n_my;
    t_sum               w_sx, w_sy;
    logic signed [31:0] n_px, n_py;
    logic               n_clip_x, n_clip_y;

    // Fold the first-quadrant result into the beam's quadrant
    always_comb begin
        unique case (i_side.quad)
            QUAD_1: begin
                n_c = 32'(-i_y);
                n_s = 32'(i_x);
            end
            QUAD_2: begin
                n_c = 32'(-i_x);
                n_s = 32'(-i_y);
            end
            QUAD_3: begin
                n_c = 32'(i_y);
                n_s = 32'(-i_x);
            end
            default: begin
                n_c = 32'(i_x);
                n_s = 32'(i_y);
            end
        endcase
    end

    // Range times cosine and sine, Q.46
    always_comb begin
        n_mx = $signed({1'b0, r_side_f.range_value}) * r_c;
        n_my = $signed({1'b0, r_side_f.range_value}) * r_s;
    end

    // Round half up to Q16.16, add pose
    assign w_sx = SW'(r_side_m.pose_x) + SW'((r_mx + ROUND_HALF) >>> 30);
    assign w_sy = SW'(r_side_m.pose_y) + SW'((r_my + ROUND_HALF) >>> 30);

    // Saturate each coordinate to 32 bits
    always_comb begin
        n_clip_x = 1'b1;
        n_clip_y = 1'b1;
        if (w_sx > SAT_MAX) begin
            n_px = 32'(SAT_MAX);
        end else if (w_sx < SAT_MIN) begin
            n_px = 32'(SAT_MIN);
        end else begin
            n_px     = 32'(w_sx);
            n_clip_x = 1'b0;
        end
        if (w_sy > SAT_MAX) begin
            n_py = 32'(SAT_MAX);
        end else if (w_sy < SAT_MIN) begin
            n_py = 32'(SAT_MIN);
        end else begin
            n_py     = 32'(w_sy);
            n_clip_y = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_f <= 1'b0;
            r_valid_m <= 1'b0;
            r_valid_o <= 1'b0;
        end else begin
            r_valid_f <= i_valid;
            r_valid_m <= r_valid_f;
            r_valid_o <= r_valid_m;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c          <= n_c;
        r_s          <= n_s;
        r_side_f     <= i_side;
        r_mx         <= n_mx;
        r_my         <= n_my;
        r_side_m     <= r_side_f;
        o_point_x    <= n_px;
        o_point_y    <= n_py;
        o_point_last <= r_side_m.scan_end;
        o_clipped    <= n_clip_x | n_clip_y;
    end

    assign o_valid = r_valid_o;

endmodule

### hdl/lptc_checker.sv
// Port-level checks of the lidar polar to Cartesian unit, bound to the top.
`include "lidar_polar_to_cartesian_unit_assert.svh"

module lptc_checker
    import lptc_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               i_scan_end,
    input logic               o_valid,
    input logic signed [31:0] o_point_x,
    input logic signed [31:0] o_point_y,
    input logic               o_point_last,
    input logic               o_clipped
);

    localparam int NS  = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int LAT = NS + 5;

    logic w_on_bound;

    // Either coordinate sits on a saturation bound
    assign w_on_bound = (o_point_x == 32'sh7FFFFFFF) || (o_point_x == 32'sh80000000)
                     || (o_point_y == 32'sh7FFFFFFF) || (o_point_y == 32'sh80000000);

    // Results leave the pipe empty after reset
    `LPTC_ASSERT_ALWAYS(a_reset_empty, !i_rst_n, ##1 !o_valid, "result right after reset")

    // Every result stems from a request taken a fixed latency earlier
    `LPTC_ASSERT_IMP(a_latency, o_valid, $past(start && !busy, LAT), "result without request")

    // End-of-scan tag stays with its beam
    `LPTC_ASSERT_IMP(a_last_tag, o_valid, o_point_last == $past(i_scan_end, LAT), "scan tag lost")

    // A clipped point sits on a saturation bound
    `LPTC_ASSERT_IMP(a_clip_bound, o_valid && o_clipped, w_on_bound, "clip flag off bound")

endmodule

bind lidar_polar_to_cartesian_unit lptc_checker #(
    .CORDIC_STAGES (CORDIC_STAGES)
) u_lptc_checker (.*);
